@@ rtl/ldps_pkg.sv @@
// shared widths, status codes, sequencer states and unit request types
`default_nettype none
package ldps_pkg;
   localparam int W  = 30;
   localparam int SW = W + 2;
   localparam int PW = 2 * W + 2;
   localparam int CW = $clog2(2 * W + 1);

   localparam logic [1:0] STATUS_NONE  = 2'd0;
   localparam logic [1:0] STATUS_NOPOS = 2'd1;
   localparam logic [1:0] STATUS_POS   = 2'd2;

   typedef struct packed {
      logic start;
      logic wide;
   } div_req_type;

   typedef enum logic [19:0] {
      ST_IDLE   = 20'h00001,
      ST_EU_DIV = 20'h00002,
      ST_EU_MUL = 20'h00004,
      ST_GCD    = 20'h00008,
      ST_K1     = 20'h00010,
      ST_K2     = 20'h00020,
      ST_XS     = 20'h00040,
      ST_XQ     = 20'h00080,
      ST_XM     = 20'h00100,
      ST_XR     = 20'h00200,
      ST_YS     = 20'h00400,
      ST_YQ     = 20'h00800,
      ST_YM     = 20'h01000,
      ST_YR     = 20'h02000,
      ST_AX     = 20'h04000,
      ST_BY     = 20'h08000,
      ST_YMAX   = 20'h10000,
      ST_XMAX   = 20'h20000,
      ST_CNT    = 20'h40000,
      ST_FIN    = 20'h80000
   } state_type;
endpackage
`default_nettype wire

@@ rtl/ldps_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module ldps_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ldps_pkg::div_req_type       req,
   input  wire logic [2*ldps_pkg::W-1:0]    num,
   input  wire logic [ldps_pkg::W-1:0]      den,
   output logic                             done,
   output logic [ldps_pkg::W-1:0]           quot,
   output logic [ldps_pkg::W-1:0]           rem
);
   localparam int W  = ldps_pkg::W;
   localparam int CW = ldps_pkg::CW;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [2*W-1:0] n_ff, n_in;
   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  d_ff, d_in;
   logic [W:0]    trial;
   logic [W:0]    diff;
   logic          ge;

   always_comb begin
      trial = {r_ff, n_ff[2*W-1]};
      diff  = trial - {1'b0, d_ff};
      ge    = trial >= {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (req.start) begin
         busy_in = 1'b1;
         n_in    = req.wide ? num : {num[W-1:0], {W{1'b0}}};
         cnt_in  = req.wide ? CW'(2 * W) : CW'(W);
         r_in    = '0;
         d_in    = den;
      end else if (busy_ff) begin
         r_in   = ge ? diff[W-1:0] : trial[W-1:0];
         n_in   = {n_ff[2*W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = n_ff[W-1:0];
   assign rem  = r_ff;
endmodule
`default_nettype wire

@@ rtl/ldps_mul.sv @@
// two-lane shift-add multiplier, one multiplier bit per cycle, msb first
`default_nettype none
module ldps_mul (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [ldps_pkg::SW-1:0]   m0,
   input  wire logic [ldps_pkg::SW-1:0]   m1,
   input  wire logic [ldps_pkg::W-1:0]    mq,
   output logic                           done,
   output logic [ldps_pkg::PW-1:0]        p0,
   output logic [ldps_pkg::PW-1:0]        p1
);
   localparam int W  = ldps_pkg::W;
   localparam int SW = ldps_pkg::SW;
   localparam int PW = ldps_pkg::PW;
   localparam int CW = ldps_pkg::CW;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  q_ff, q_in;
   logic [PW-1:0] e0_ff, e0_in, e1_ff, e1_in;
   logic [PW-1:0] acc0_ff, acc0_in, acc1_ff, acc1_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      e0_in   = e0_ff;
      e1_in   = e1_ff;
      acc0_in = acc0_ff;
      acc1_in = acc1_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         q_in    = mq;
         // sign-extended multiplicands, two's complement
         e0_in   = {{(PW-SW){m0[SW-1]}}, m0};
         e1_in   = {{(PW-SW){m1[SW-1]}}, m1};
         acc0_in = '0;
         acc1_in = '0;
      end else if (busy_ff) begin
         acc0_in = {acc0_ff[PW-2:0], 1'b0} + (q_ff[W-1] ? e0_ff : '0);
         acc1_in = {acc1_ff[PW-2:0], 1'b0} + (q_ff[W-1] ? e1_ff : '0);
         q_in    = {q_ff[W-2:0], 1'b0};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      e0_ff   <= e0_in;
      e1_ff   <= e1_in;
      acc0_ff <= acc0_in;
      acc1_ff <= acc1_in;
   end

   assign done = done_ff;
   assign p0   = acc0_ff;
   assign p1   = acc1_ff;
endmodule
`default_nettype wire

@@ rtl/linear_diophantine_positive_solver.sv @@
// Solver for a*x + b*y = c over positive integers.
// A transaction on the req_ channel carries coef_a, coef_b and rhs_c; one
// transaction on the rsp_ channel returns status, solution count, least
// positive x and y, and greatest x and y among positive solutions.
// One transaction is worked on at a time; req_stall is low only while the
// sequencer is idle. The work runs on one bit-serial divider (W or 2W
// quotient bits a pass) and one two-lane bit-serial multiplier (W bits
// a pass). Each Euclid step costs one divide plus one multiply; the tail
// is up to 16 more unit passes. A zero coefficient goes straight to the
// finish state with status none.
// The result sits in an output register; a new transaction is taken while
// it waits, and the sequencer holds the next result until rsp_stall drops.
// Synchronous reset clears the sequencer and the output valid.
`default_nettype none
module linear_diophantine_positive_solver (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [ldps_pkg::W-1:0]  req_coef_a,
   input  wire logic [ldps_pkg::W-1:0]  req_coef_b,
   input  wire logic [ldps_pkg::W-1:0]  req_rhs_c,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [ldps_pkg::W-1:0]       rsp_solution_count,
   output logic [ldps_pkg::W-1:0]       rsp_least_x,
   output logic [ldps_pkg::W-1:0]       rsp_least_y,
   output logic [ldps_pkg::W-1:0]       rsp_greatest_x,
   output logic [ldps_pkg::W-1:0]       rsp_greatest_y
);
   localparam int W  = ldps_pkg::W;
   localparam int SW = ldps_pkg::SW;
   localparam int PW = ldps_pkg::PW;

   ldps_pkg::state_type state_ff, state_in;
   logic        launched_ff, launched_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [W-1:0]  a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [W-1:0]  r0_ff, r0_in, r1_ff, r1_in, qq_ff, qq_in;
   logic [SW-1:0] s0_ff, s0_in, s1_ff, s1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [W-1:0]  q_ff, q_in, k1_ff, k1_in, k2_ff, k2_in;
   logic [W-1:0]  rs_ff, rs_in, qm_ff, qm_in;
   logic [PW-1:0] prod_ff, prod_in, ax_ff, ax_in, by_ff, by_in;
   logic [W-1:0]  xmin_ff, xmin_in, ymin_ff, ymin_in;
   logic [W-1:0]  ymax_ff, ymax_in, xmax_ff, xmax_in, cnt_ff, cnt_in;
   logic [1:0]    st_ff, st_in;

   logic [1:0]    o_status_ff, o_status_in;
   logic [W-1:0]  o_cnt_ff, o_cnt_in, o_lx_ff, o_lx_in, o_ly_ff, o_ly_in;
   logic [W-1:0]  o_gx_ff, o_gx_in, o_gy_ff, o_gy_in;

   ldps_pkg::div_req_type div_req;
   logic [2*W-1:0] div_num;
   logic [W-1:0]   div_den, div_quot, div_rem;
   logic           div_done;
   logic           mul_start, mul_done;
   logic [SW-1:0]  mul_m0, mul_m1;
   logic [W-1:0]   mul_mq;
   logic [PW-1:0]  mul_p0, mul_p1;

   logic           is_div, is_mul, accept, out_free;
   logic [SW-1:0]  abs_s0, abs_t0;

   ldps_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   ldps_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .m0    (mul_m0),
      .m1    (mul_m1),
      .mq    (mul_mq),
      .done  (mul_done),
      .p0    (mul_p0),
      .p1    (mul_p1)
   );

   assign abs_s0 = s0_ff[SW-1] ? (SW'(0) - s0_ff) : s0_ff;
   assign abs_t0 = t0_ff[SW-1] ? (SW'(0) - t0_ff) : t0_ff;

   // operand selection for the shared units
   always_comb begin
      is_div   = 1'b0;
      is_mul   = 1'b0;
      div_num  = '0;
      div_den  = k1_ff;
      div_req.wide = 1'b0;
      mul_m0   = '0;
      mul_m1   = '0;
      mul_mq   = '0;
      unique case (state_ff)
         ldps_pkg::ST_EU_DIV: begin
            is_div = 1'b1; div_num = (2*W)'(r0_ff); div_den = r1_ff;
         end
         ldps_pkg::ST_GCD: begin
            is_div = 1'b1; div_num = (2*W)'(c_ff); div_den = r0_ff;
         end
         ldps_pkg::ST_K1: begin
            is_div = 1'b1; div_num = (2*W)'(b_ff); div_den = r0_ff;
         end
         ldps_pkg::ST_K2: begin
            is_div = 1'b1; div_num = (2*W)'(a_ff); div_den = r0_ff;
         end
         ldps_pkg::ST_XS: begin
            is_div = 1'b1; div_num = (2*W)'(abs_s0); div_den = k1_ff;
            div_req.wide = 1'b1;
         end
         ldps_pkg::ST_XQ: begin
            is_div = 1'b1; div_num = (2*W)'(q_ff); div_den = k1_ff;
         end
         ldps_pkg::ST_XR: begin
            is_div = 1'b1; div_num = prod_ff[2*W-1:0]; div_den = k1_ff;
            div_req.wide = 1'b1;
         end
         ldps_pkg::ST_YS: begin
            is_div = 1'b1; div_num = (2*W)'(abs_t0); div_den = k2_ff;
            div_req.wide = 1'b1;
         end
         ldps_pkg::ST_YQ: begin
            is_div = 1'b1; div_num = (2*W)'(q_ff); div_den = k2_ff;
         end
         ldps_pkg::ST_YR: begin
            is_div = 1'b1; div_num = prod_ff[2*W-1:0]; div_den = k2_ff;
            div_req.wide = 1'b1;
         end
         ldps_pkg::ST_YMAX: begin
            is_div = 1'b1; div_num = (2*W)'(c_ff - ax_ff[W-1:0]); div_den = b_ff;
         end
         ldps_pkg::ST_XMAX: begin
            is_div = 1'b1; div_num = (2*W)'(c_ff - by_ff[W-1:0]); div_den = a_ff;
         end
         ldps_pkg::ST_CNT: begin
            is_div = 1'b1; div_num = (2*W)'(ymax_ff - ymin_ff); div_den = k2_ff;
         end
         ldps_pkg::ST_EU_MUL: begin
            is_mul = 1'b1; mul_m0 = s1_ff; mul_m1 = t1_ff; mul_mq = qq_ff;
         end
         ldps_pkg::ST_XM, ldps_pkg::ST_YM: begin
            is_mul = 1'b1; mul_m0 = SW'(rs_ff); mul_mq = qm_ff;
         end
         ldps_pkg::ST_AX: begin
            is_mul = 1'b1; mul_m0 = SW'(a_ff); mul_mq = xmin_ff;
         end
         ldps_pkg::ST_BY: begin
            is_mul = 1'b1; mul_m0 = SW'(b_ff); mul_mq = ymin_ff;
         end
         ldps_pkg::ST_IDLE, ldps_pkg::ST_FIN: begin
         end
         default: begin
         end
      endcase
      div_req.start = is_div && !launched_ff;
      mul_start     = is_mul && !launched_ff;
   end

   assign req_stall = (state_ff != ldps_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      launched_in = launched_ff;
      if (div_done || mul_done) launched_in = 1'b0;
      else if (div_req.start || mul_start) launched_in = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      a_in = a_ff; b_in = b_ff; c_in = c_ff;
      r0_in = r0_ff; r1_in = r1_ff; qq_in = qq_ff;
      s0_in = s0_ff; s1_in = s1_ff; t0_in = t0_ff; t1_in = t1_ff;
      q_in = q_ff; k1_in = k1_ff; k2_in = k2_ff; rs_in = rs_ff; qm_in = qm_ff;
      prod_in = prod_ff; ax_in = ax_ff; by_in = by_ff;
      xmin_in = xmin_ff; ymin_in = ymin_ff;
      ymax_in = ymax_ff; xmax_in = xmax_ff; cnt_in = cnt_ff; st_in = st_ff;
      o_status_in = o_status_ff; o_cnt_in = o_cnt_ff;
      o_lx_in = o_lx_ff; o_ly_in = o_ly_ff; o_gx_in = o_gx_ff; o_gy_in = o_gy_ff;
      unique case (state_ff)
         ldps_pkg::ST_IDLE: begin
            if (accept) begin
               a_in = req_coef_a; b_in = req_coef_b; c_in = req_rhs_c;
               r0_in = req_coef_a; r1_in = req_coef_b;
               s0_in = SW'(1); s1_in = '0; t0_in = '0; t1_in = SW'(1);
               if (req_coef_a == '0 || req_coef_b == '0) begin
                  st_in = ldps_pkg::STATUS_NONE;
                  state_in = ldps_pkg::ST_FIN;
               end else begin
                  state_in = ldps_pkg::ST_EU_DIV;
               end
            end
         end
         ldps_pkg::ST_EU_DIV: if (div_done) begin
            qq_in = div_quot; r0_in = r1_ff; r1_in = div_rem;
            state_in = ldps_pkg::ST_EU_MUL;
         end
         ldps_pkg::ST_EU_MUL: if (mul_done) begin
            s0_in = s1_ff; s1_in = s0_ff - mul_p0[SW-1:0];
            t0_in = t1_ff; t1_in = t0_ff - mul_p1[SW-1:0];
            state_in = (r1_ff == '0) ? ldps_pkg::ST_GCD : ldps_pkg::ST_EU_DIV;
         end
         ldps_pkg::ST_GCD: if (div_done) begin
            q_in = div_quot;
            if (div_rem != '0) begin
               st_in = ldps_pkg::STATUS_NONE;
               state_in = ldps_pkg::ST_FIN;
            end else begin
               state_in = ldps_pkg::ST_K1;
            end
         end
         ldps_pkg::ST_K1: if (div_done) begin
            k1_in = div_quot; state_in = ldps_pkg::ST_K2;
         end
         ldps_pkg::ST_K2: if (div_done) begin
            k2_in = div_quot; state_in = ldps_pkg::ST_XS;
         end
         ldps_pkg::ST_XS: if (div_done) begin
            // negative coefficient folds to k - remainder
            rs_in = (s0_ff[SW-1] && div_rem != '0) ? k1_ff - div_rem : div_rem;
            state_in = ldps_pkg::ST_XQ;
         end
         ldps_pkg::ST_XQ: if (div_done) begin
            qm_in = div_rem; state_in = ldps_pkg::ST_XM;
         end
         ldps_pkg::ST_XM: if (mul_done) begin
            prod_in = mul_p0; state_in = ldps_pkg::ST_XR;
         end
         ldps_pkg::ST_XR: if (div_done) begin
            xmin_in = (div_rem == '0) ? k1_ff : div_rem;
            state_in = ldps_pkg::ST_YS;
         end
         ldps_pkg::ST_YS: if (div_done) begin
            rs_in = (t0_ff[SW-1] && div_rem != '0) ? k2_ff - div_rem : div_rem;
            state_in = ldps_pkg::ST_YQ;
         end
         ldps_pkg::ST_YQ: if (div_done) begin
            qm_in = div_rem; state_in = ldps_pkg::ST_YM;
         end
         ldps_pkg::ST_YM: if (mul_done) begin
            prod_in = mul_p0; state_in = ldps_pkg::ST_YR;
         end
         ldps_pkg::ST_YR: if (div_done) begin
            ymin_in = (div_rem == '0) ? k2_ff : div_rem;
            state_in = ldps_pkg::ST_AX;
         end
         ldps_pkg::ST_AX: if (mul_done) begin
            ax_in = mul_p0;
            if (mul_p0 + PW'(b_ff) > PW'(c_ff)) begin
               st_in = ldps_pkg::STATUS_NOPOS;
               state_in = ldps_pkg::ST_FIN;
            end else begin
               state_in = ldps_pkg::ST_BY;
            end
         end
         ldps_pkg::ST_BY: if (mul_done) begin
            by_in = mul_p0; state_in = ldps_pkg::ST_YMAX;
         end
         ldps_pkg::ST_YMAX: if (div_done) begin
            ymax_in = div_quot; state_in = ldps_pkg::ST_XMAX;
         end
         ldps_pkg::ST_XMAX: if (div_done) begin
            xmax_in = div_quot; state_in = ldps_pkg::ST_CNT;
         end
         ldps_pkg::ST_CNT: if (div_done) begin
            cnt_in = div_quot + W'(1);
            st_in = ldps_pkg::STATUS_POS;
            state_in = ldps_pkg::ST_FIN;
         end
         ldps_pkg::ST_FIN: if (out_free) begin
            rsp_valid_in = 1'b1;
            o_status_in = st_ff;
            o_cnt_in = '0; o_lx_in = '0; o_ly_in = '0; o_gx_in = '0; o_gy_in = '0;
            if (st_ff != ldps_pkg::STATUS_NONE) begin
               o_lx_in = xmin_ff; o_ly_in = ymin_ff;
            end
            if (st_ff == ldps_pkg::STATUS_POS) begin
               o_cnt_in = cnt_ff; o_gx_in = xmax_ff; o_gy_in = ymax_ff;
            end
            state_in = ldps_pkg::ST_IDLE;
         end
         default: state_in = ldps_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ldps_pkg::ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in;
      r0_ff <= r0_in; r1_ff <= r1_in; qq_ff <= qq_in;
      s0_ff <= s0_in; s1_ff <= s1_in; t0_ff <= t0_in; t1_ff <= t1_in;
      q_ff <= q_in; k1_ff <= k1_in; k2_ff <= k2_in; rs_ff <= rs_in; qm_ff <= qm_in;
      prod_ff <= prod_in; ax_ff <= ax_in; by_ff <= by_in;
      xmin_ff <= xmin_in; ymin_ff <= ymin_in;
      ymax_ff <= ymax_in; xmax_ff <= xmax_in; cnt_ff <= cnt_in; st_ff <= st_in;
      o_status_ff <= o_status_in; o_cnt_ff <= o_cnt_in;
      o_lx_ff <= o_lx_in; o_ly_ff <= o_ly_in; o_gx_ff <= o_gx_in; o_gy_ff <= o_gy_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = o_status_ff;
   assign rsp_solution_count = o_cnt_ff;
   assign rsp_least_x        = o_lx_ff;
   assign rsp_least_y        = o_ly_ff;
   assign rsp_greatest_x     = o_gx_ff;
   assign rsp_greatest_y     = o_gy_ff;
endmodule
`default_nettype wire
